// File: hw/rtl/cdn_pkg.sv
`timescale 1ns / 1ps
// shared widths, month codes, divide-by-25 constants and stage payload types
// for the calendar date neighbours block; no dependencies

package cdn_pkg;

   // field widths
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;

   // default for the largest valid year
   localparam int YEAR_MAX_DEFAULT = 9999;
   // year limit compare width, wider than the 14-bit year field
   localparam int YEAR_LIMIT_W = 17;

   // month codes
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
   localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // month lengths
   localparam logic [DAY_W-1:0] DAYS_LONG     = 5'd31;
   localparam logic [DAY_W-1:0] DAYS_SHORT    = 5'd30;
   localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;
   localparam logic [DAY_W-1:0] DAYS_FEB      = 5'd28;
   localparam logic [DAY_W-1:0] DAYS_NONE     = 5'd0;
   localparam logic [DAY_W-1:0] DAY_FIRST     = 5'd1;

   // floor(y / 25) = (y * 5243) >> 17, exact for every 14-bit year
   localparam int DIV25_MULT_W = 13;
   localparam logic [DIV25_MULT_W-1:0] DIV25_MULT = 13'd5243;
   localparam int DIV25_SHIFT = 17;
   localparam int PROD_W = YEAR_W + DIV25_MULT_W;
   localparam int QUOT_W = PROD_W - DIV25_SHIFT;

   // days in a month; zero for a month code outside the calendar
   function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                   input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] days;
      case (month)
         MONTH_FEB: days = leap ? DAYS_FEB_LEAP : DAYS_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = DAYS_SHORT;
         MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
         MONTH_AUG, MONTH_OCT, MONTH_DEC: days = DAYS_LONG;
         default: days = DAYS_NONE;
      endcase
      return days;
   endfunction

   // stage 1: captured date and the divide-by-25 product
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [PROD_W-1:0]  prod;
   } s1_type;

   // stage 2: leap flag, month lengths and date check
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic               leap;
      logic [DAY_W-1:0]   len;
      logic [DAY_W-1:0]   prev_len;
      logic               valid;
   } s2_type;

   // stage 3: the result beat
   typedef struct packed {
      logic               date_valid;
      logic               leap_year;
      logic [DAY_W-1:0]   month_length;
      logic               prev_exists;
      logic [YEAR_W-1:0]  prev_year;
      logic [MONTH_W-1:0] prev_month;
      logic [DAY_W-1:0]   prev_day;
      logic [YEAR_W-1:0]  next_year;
      logic [MONTH_W-1:0] next_month;
      logic [DAY_W-1:0]   next_day;
   } rsp_type;

endpackage

// File: hw/rtl/cdn_req_if.sv
`timescale 1ns / 1ps
// request channel: one date per beat, valid/ready handshake
// depends on cdn_pkg for field widths

interface cdn_req_if;
   logic                         valid;
   logic                         ready;
   logic [cdn_pkg::YEAR_W-1:0]   year;
   logic [cdn_pkg::MONTH_W-1:0]  month;
   logic [cdn_pkg::DAY_W-1:0]    day;

   modport source (output valid, year, month, day, input ready);
   modport sink (input valid, year, month, day, output ready);
endinterface

// File: hw/rtl/cdn_rsp_if.sv
`timescale 1ns / 1ps
// response channel: date check and neighbour dates, valid/ready handshake
// depends on cdn_pkg for field widths

interface cdn_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         date_valid;
   logic                         leap_year;
   logic [cdn_pkg::DAY_W-1:0]    month_length;
   logic                         prev_exists;
   logic [cdn_pkg::YEAR_W-1:0]   prev_year;
   logic [cdn_pkg::MONTH_W-1:0]  prev_month;
   logic [cdn_pkg::DAY_W-1:0]    prev_day;
   logic [cdn_pkg::YEAR_W-1:0]   next_year;
   logic [cdn_pkg::MONTH_W-1:0]  next_month;
   logic [cdn_pkg::DAY_W-1:0]    next_day;

   modport source (output valid, date_valid, leap_year, month_length, prev_exists,
                   prev_year, prev_month, prev_day, next_year, next_month, next_day,
                   input ready);
   modport sink (input valid, date_valid, leap_year, month_length, prev_exists,
                 prev_year, prev_month, prev_day, next_year, next_month, next_day,
                 output ready);
endinterface

// File: hw/rtl/cdn_pipe_stage.sv
`timescale 1ns / 1ps
// one pipeline register stage with its valid bit and handshake
// a stage takes a new beat when empty or when its contents move on

module cdn_pipe_stage #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff;
   logic             valid_in;
   logic [WIDTH-1:0] data_ff;

   // open when empty or draining this cycle
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload loads only on an accepted beat
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: hw/rtl/calendar_date_neighbours.sv
`timescale 1ns / 1ps
// top level: Gregorian date check with previous and next date
// depends on cdn_pkg, cdn_req_if, cdn_rsp_if and cdn_pipe_stage

// Checks a Gregorian date (year, month, day) and returns in one response beat
// whether it is valid, whether its year is a leap year, the month length, and
// the previous and next dates. A new date is taken every cycle while the
// pipeline is not stalled; each result passes through three register
// stages: the divide-by-25 reciprocal multiply, the leap rule with the month
// length lookup and date check, and the step to the neighbouring dates.
// Backpressure on the response side stalls the stages without losing beats.
// Years from 1 to YEAR_MAX count as valid. For an invalid date all previous
// and next fields and prev_exists read zero; January 1 of year 1 gives
// prev_exists low with December 31 of year 0 as the previous date.

module calendar_date_neighbours #(
   parameter int YEAR_MAX = cdn_pkg::YEAR_MAX_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   cdn_req_if.sink   req_bus,
   cdn_rsp_if.source rsp_bus
);

   localparam logic [cdn_pkg::YEAR_LIMIT_W-1:0] YEAR_LIMIT =
      cdn_pkg::YEAR_LIMIT_W'(YEAR_MAX);
   localparam int YW = cdn_pkg::YEAR_W;
   localparam int MW = cdn_pkg::MONTH_W;
   localparam int DW = cdn_pkg::DAY_W;

   cdn_pkg::s1_type  s1_in, s1_out;
   cdn_pkg::s2_type  s2_in, s2_out;
   cdn_pkg::rsp_type s3_in, s3_out;
   logic             s1_valid, s1_ready;
   logic             s2_valid, s2_ready;

   // stage 1: capture date, reciprocal multiply for the divide by 25
   always_comb begin
      s1_in.year  = req_bus.year;
      s1_in.month = req_bus.month;
      s1_in.day   = req_bus.day;
      s1_in.prod  = cdn_pkg::PROD_W'(req_bus.year) *
                    cdn_pkg::PROD_W'(cdn_pkg::DIV25_MULT);
   end

   cdn_pipe_stage #(.WIDTH($bits(cdn_pkg::s1_type))) u_stage1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (s1_in),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_out)
   );

   // stage 2: leap rule, month lengths and date check
   logic [cdn_pkg::QUOT_W-1:0] quot;
   logic [YW-1:0]              quot25;
   logic [YW-1:0]              rem25;
   logic                       div25;
   logic                       year_ok;

   always_comb begin
      quot   = s1_out.prod[cdn_pkg::PROD_W-1:cdn_pkg::DIV25_SHIFT];
      quot25 = YW'({quot, 4'b0}) + YW'({quot, 3'b0}) + YW'(quot);
      rem25  = s1_out.year - quot25;
      div25  = (rem25 == '0);
      year_ok = (s1_out.year != '0) &&
                (cdn_pkg::YEAR_LIMIT_W'(s1_out.year) <= YEAR_LIMIT);

      s2_in.year     = s1_out.year;
      s2_in.month    = s1_out.month;
      s2_in.day      = s1_out.day;
      // divisible by 4, and not a century unless divisible by 400
      s2_in.leap     = (s1_out.year[1:0] == 2'b0) &&
                       (!div25 || (s1_out.year[3:0] == 4'b0));
      s2_in.len      = cdn_pkg::month_days(s2_in.leap, s1_out.month);
      s2_in.prev_len = cdn_pkg::month_days(s2_in.leap, s1_out.month - MW'(1));
      s2_in.valid    = year_ok && (s2_in.len != cdn_pkg::DAYS_NONE) &&
                       (s1_out.day != '0) && (s1_out.day <= s2_in.len);
   end

   cdn_pipe_stage #(.WIDTH($bits(cdn_pkg::s2_type))) u_stage2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s2_in),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_out)
   );

   // stage 3: step back and forward one day
   always_comb begin
      s3_in.date_valid   = s2_out.valid;
      s3_in.leap_year    = s2_out.leap;
      s3_in.month_length = s2_out.len;
      s3_in.prev_exists  = 1'b0;
      s3_in.prev_year    = '0;
      s3_in.prev_month   = '0;
      s3_in.prev_day     = '0;
      s3_in.next_year    = '0;
      s3_in.next_month   = '0;
      s3_in.next_day     = '0;

      if (s2_out.valid) begin
         // previous date
         if (s2_out.day > cdn_pkg::DAY_FIRST) begin
            s3_in.prev_year  = s2_out.year;
            s3_in.prev_month = s2_out.month;
            s3_in.prev_day   = s2_out.day - DW'(1);
         end else if (s2_out.month > cdn_pkg::MONTH_JAN) begin
            s3_in.prev_year  = s2_out.year;
            s3_in.prev_month = s2_out.month - MW'(1);
            s3_in.prev_day   = s2_out.prev_len;
         end else begin
            s3_in.prev_year  = s2_out.year - YW'(1);
            s3_in.prev_month = cdn_pkg::MONTH_DEC;
            s3_in.prev_day   = cdn_pkg::DAYS_LONG;
         end
         s3_in.prev_exists = (s3_in.prev_year != '0);

         // next date
         if (s2_out.day < s2_out.len) begin
            s3_in.next_year  = s2_out.year;
            s3_in.next_month = s2_out.month;
            s3_in.next_day   = s2_out.day + DW'(1);
         end else if (s2_out.month < cdn_pkg::MONTH_DEC) begin
            s3_in.next_year  = s2_out.year;
            s3_in.next_month = s2_out.month + MW'(1);
            s3_in.next_day   = cdn_pkg::DAY_FIRST;
         end else begin
            s3_in.next_year  = s2_out.year + YW'(1);
            s3_in.next_month = cdn_pkg::MONTH_JAN;
            s3_in.next_day   = cdn_pkg::DAY_FIRST;
         end
      end
   end

   cdn_pipe_stage #(.WIDTH($bits(cdn_pkg::rsp_type))) u_stage3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s3_in),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (s3_out)
   );

   // response beat fields
   assign rsp_bus.date_valid   = s3_out.date_valid;
   assign rsp_bus.leap_year    = s3_out.leap_year;
   assign rsp_bus.month_length = s3_out.month_length;
   assign rsp_bus.prev_exists  = s3_out.prev_exists;
   assign rsp_bus.prev_year    = s3_out.prev_year;
   assign rsp_bus.prev_month   = s3_out.prev_month;
   assign rsp_bus.prev_day     = s3_out.prev_day;
   assign rsp_bus.next_year    = s3_out.next_year;
   assign rsp_bus.next_month   = s3_out.next_month;
   assign rsp_bus.next_day     = s3_out.next_day;

`ifndef SYNTHESIS
   // an accepted request beat always occupies stage 1 next cycle
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> s1_valid)
      else $error("accepted request beat did not reach stage 1");

   // a valid date has a real month length
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.date_valid |-> rsp_bus.month_length != '0)
      else $error("valid date with zero month length");

   // invalid dates carry zero prev_exists, prev_day and next_day
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.date_valid |->
         !rsp_bus.prev_exists && rsp_bus.prev_day == '0 && rsp_bus.next_day == '0)
      else $error("invalid date with nonzero neighbour fields");

   // next date of a valid date is a real month and day
   a_next_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.date_valid |->
         rsp_bus.next_month >= cdn_pkg::MONTH_JAN &&
         rsp_bus.next_month <= cdn_pkg::MONTH_DEC &&
         rsp_bus.next_day != '0)
      else $error("next date out of calendar range");
`endif

endmodule
